/* hdl/pvp_pkg.sv */
// ----------------------------------------------------------------------------
// pvp_pkg: shared types and constants for the vertex projection block
// Register indexes, divider depth, saturation limits and pipeline sideband.
// ----------------------------------------------------------------------------
package pvp_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_ROT_ROW_ZERO = 3'd0,
    REG_ROT_ROW_ONE  = 3'd1,
    REG_ROT_ROW_TWO  = 3'd2,
    REG_SHIFT_X      = 3'd3,
    REG_SHIFT_Y      = 3'd4,
    REG_SHIFT_Z      = 3'd5,
    REG_FOCAL        = 3'd6,
    REG_ORIGIN       = 3'd7
  } cfg_reg_t;

  localparam int CFG_DATA_W = 48;
  localparam int ENTRY_W    = 16;
  localparam int FRAC_BITS  = 14;
  localparam int FOCAL_W    = 16;
  localparam int ORIGIN_W   = 12;

  // Quotient bits kept; the top step of the divider only flags overflow
  localparam int QUO_BITS  = 18;
  localparam int DIV_STEPS = QUO_BITS + 1;

  localparam logic signed [15:0] SAT_HI = 16'sh7FFF;
  localparam logic signed [15:0] SAT_LO = -16'sh8000;

  localparam logic [47:0] ROT_ROW_ZERO_RST = 48'h0000_0000_4000;
  localparam logic [47:0] ROT_ROW_ONE_RST  = 48'h0000_4000_0000;
  localparam logic [47:0] ROT_ROW_TWO_RST  = 48'h4000_0000_0000;
  localparam logic [15:0] FOCAL_RST        = 16'd400;

  // Sideband that travels alongside the divider
  typedef struct packed {
    logic neg_x;
    logic neg_y;
    logic depth_zero;
  } side_t;

endpackage

/* hdl/perspective_vertex_projection.sv */
// ----------------------------------------------------------------------------
// perspective_vertex_projection: pinhole projection of Q16.16 vertices
// Rotate, translate and divide by depth, giving saturated screen pixels.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one vertex per transaction, x, y, z packed from the low bits of
//           in_tdata, each COORD_WIDTH bits signed Q16.16.
//   out_* : one result per vertex; out_tdata holds screen_x then screen_y,
//           out_tuser holds depth_zero then clipped.
//   cfg_* : register writes (index, data); always ready, take effect at
//           once. Write only while no vertex is in flight.
// Timing: one vertex per clock while the receiver does not stall. The path from
//   input transaction to result is one multiply stage, one sum stage, one absolute
//   value stage, one scale multiply stage, 19 divider stages (one quotient
//   bit each) and the output register.
// Reset clears all valid bits and loads the identity matrix, zero
//   translation, focal length 400 and origin zero.
// A stalled receiver freezes the whole pipeline: in_tready falls in the same
//   cycle and no vertex is lost or repeated.
// ----------------------------------------------------------------------------
module perspective_vertex_projection #(
  parameter int COORD_WIDTH = 32,
  localparam int IN_W = ((3 * COORD_WIDTH + 7) / 8) * 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // point_x, point_y, point_z (COORD_WIDTH each), zero padded
  input  logic [IN_W-1:0]           in_tdata,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // screen_x [15:0], screen_y [31:16]
  output logic [31:0]               out_tdata,
  // depth_zero [0], clipped [1]
  output logic [1:0]                out_tuser,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [2:0]                cfg_index,
  input  logic [pvp_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int CW = COORD_WIDTH;
  localparam int PW = CW + pvp_pkg::ENTRY_W;
  localparam int SW = PW + 2;
  localparam int AW = ((CW + 4 > 32) ? CW + 4 : 32) + 1;
  localparam int NW = AW + pvp_pkg::FOCAL_W;
  localparam int QB = pvp_pkg::QUO_BITS;

  // Configuration registers
  logic [47:0] rot_r [3];
  logic signed [31:0] shift_r [3];
  logic [pvp_pkg::FOCAL_W-1:0] focal_r;
  logic [2*pvp_pkg::ORIGIN_W-1:0] origin_r;
  pvp_pkg::cfg_reg_t cfg_sel;

  assign cfg_ready = 1'b1;
  assign cfg_sel   = pvp_pkg::cfg_reg_t'(cfg_index);

  // Load a register on each write transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_r[0]   <= pvp_pkg::ROT_ROW_ZERO_RST;
      rot_r[1]   <= pvp_pkg::ROT_ROW_ONE_RST;
      rot_r[2]   <= pvp_pkg::ROT_ROW_TWO_RST;
      shift_r[0] <= '0;
      shift_r[1] <= '0;
      shift_r[2] <= '0;
      focal_r    <= pvp_pkg::FOCAL_RST;
      origin_r   <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_sel)
        pvp_pkg::REG_ROT_ROW_ZERO: rot_r[0]   <= cfg_data;
        pvp_pkg::REG_ROT_ROW_ONE:  rot_r[1]   <= cfg_data;
        pvp_pkg::REG_ROT_ROW_TWO:  rot_r[2]   <= cfg_data;
        pvp_pkg::REG_SHIFT_X:      shift_r[0] <= cfg_data[31:0];
        pvp_pkg::REG_SHIFT_Y:      shift_r[1] <= cfg_data[31:0];
        pvp_pkg::REG_SHIFT_Z:      shift_r[2] <= cfg_data[31:0];
        pvp_pkg::REG_FOCAL:        focal_r    <= cfg_data[15:0];
        pvp_pkg::REG_ORIGIN:       origin_r   <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  logic [pvp_pkg::ORIGIN_W-1:0] org_x, org_y;
  assign org_x = origin_r[pvp_pkg::ORIGIN_W-1:0];
  assign org_y = origin_r[2*pvp_pkg::ORIGIN_W-1:pvp_pkg::ORIGIN_W];

  // Global advance: the output register is free or being emptied
  logic en;
  logic out_valid_r;
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  // Stage 1: nine coordinate by entry products
  logic v1_r;
  logic signed [PW-1:0] prod_r [3][3];
  logic signed [PW-1:0] prod_nxt [3][3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        prod_nxt[r][k] = PW'($signed(in_tdata[k*CW +: CW]))
                       * PW'($signed(rot_r[r][k*16 +: 16]));
      end
    end
  end

  // Stage 2: row sums, floor to Q16.16, translate
  logic v2_r;
  logic signed [AW-1:0] cam_r [3];
  logic signed [AW-1:0] cam_nxt [3];
  logic signed [SW-1:0] row_sum [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      row_sum[r] = SW'(prod_r[r][0]) + SW'(prod_r[r][1]) + SW'(prod_r[r][2]);
      cam_nxt[r] = AW'($signed(row_sum[r][SW-1:pvp_pkg::FRAC_BITS]))
                 + AW'(shift_r[r]);
    end
  end

  // Stage 3: magnitudes and quotient signs
  logic v3_r;
  logic [AW-1:0] mag_r [3];
  logic [AW-1:0] mag_nxt [3];
  pvp_pkg::side_t side3_r, side3_nxt;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      mag_nxt[r] = cam_r[r][AW-1] ? AW'(-cam_r[r]) : AW'(cam_r[r]);
    end
    side3_nxt.neg_x      = cam_r[0][AW-1] ^ cam_r[2][AW-1];
    side3_nxt.neg_y      = cam_r[1][AW-1] ^ cam_r[2][AW-1];
    side3_nxt.depth_zero = (cam_r[2] == '0);
  end

  // Stage 4: scale numerators by focal length
  logic v4_r;
  logic [NW-1:0] num_x_r, num_y_r;
  logic [AW-1:0] den_r;
  pvp_pkg::side_t side4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r     <= in_tvalid;
      prod_r   <= prod_nxt;
      v2_r     <= v1_r;
      cam_r    <= cam_nxt;
      v3_r     <= v2_r;
      mag_r    <= mag_nxt;
      side3_r  <= side3_nxt;
      v4_r     <= v3_r;
      num_x_r  <= NW'(mag_r[0]) * NW'(focal_r);
      num_y_r  <= NW'(mag_r[1]) * NW'(focal_r);
      den_r    <= mag_r[2];
      side4_r  <= side3_r;
    end
  end

  // Stages 5 to 23: divide both numerators by depth
  logic                          dv_valid;
  logic [pvp_pkg::DIV_STEPS-1:0] quo_x, quo_y;
  pvp_pkg::side_t                dv_side;

  pvp_divider #(.AW(AW)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v4_r),
    .in_num_x  (num_x_r),
    .in_num_y  (num_y_r),
    .in_den    (den_r),
    .in_side   (side4_r),
    .out_valid (dv_valid),
    .out_quo_x (quo_x),
    .out_quo_y (quo_y),
    .out_side  (dv_side)
  );

  // Stage 24: apply signs and origin, saturate
  logic signed [QB+1:0] off_x, off_y;
  logic signed [QB+2:0] sum_x, sum_y;
  logic signed [15:0]   sx_nxt, sy_nxt;
  logic                 clip_nxt, clip_x, clip_y;
  logic signed [15:0]   sx_r, sy_r;
  logic                 dz_r, clip_r;

  always_comb begin
    off_x = dv_side.neg_x ? -$signed({2'b00, quo_x[QB-1:0]})
                          :  $signed({2'b00, quo_x[QB-1:0]});
    off_y = dv_side.neg_y ? -$signed({2'b00, quo_y[QB-1:0]})
                          :  $signed({2'b00, quo_y[QB-1:0]});
    sum_x = (QB+3)'(off_x) + $signed((QB+3)'(org_x));
    sum_y = $signed((QB+3)'(org_y)) - (QB+3)'(off_y);
    clip_x = 1'b1;
    clip_y = 1'b1;
    priority if (quo_x[QB]) begin
      sx_nxt = dv_side.neg_x ? pvp_pkg::SAT_LO : pvp_pkg::SAT_HI;
    end else if (sum_x > (QB+3)'(pvp_pkg::SAT_HI)) begin
      sx_nxt = pvp_pkg::SAT_HI;
    end else if (sum_x < (QB+3)'(pvp_pkg::SAT_LO)) begin
      sx_nxt = pvp_pkg::SAT_LO;
    end else begin
      sx_nxt = sum_x[15:0];
      clip_x = 1'b0;
    end
    priority if (quo_y[QB]) begin
      sy_nxt = dv_side.neg_y ? pvp_pkg::SAT_HI : pvp_pkg::SAT_LO;
    end else if (sum_y > (QB+3)'(pvp_pkg::SAT_HI)) begin
      sy_nxt = pvp_pkg::SAT_HI;
    end else if (sum_y < (QB+3)'(pvp_pkg::SAT_LO)) begin
      sy_nxt = pvp_pkg::SAT_LO;
    end else begin
      sy_nxt = sum_y[15:0];
      clip_y = 1'b0;
    end
    clip_nxt = clip_x || clip_y;
    // Zero depth: hold at the origin, never clipped
    if (dv_side.depth_zero) begin
      sx_nxt   = 16'(org_x);
      sy_nxt   = 16'(org_y);
      clip_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_valid;
      sx_r        <= sx_nxt;
      sy_r        <= sy_nxt;
      dz_r        <= dv_side.depth_zero;
      clip_r      <= clip_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {sy_r, sx_r};
  assign out_tuser  = {clip_r, dz_r};

endmodule

/* hdl/pvp_divider.sv */
// ----------------------------------------------------------------------------
// pvp_divider: pipelined restoring divider, two numerators over one divisor
// One quotient bit per stage; the first stage flags quotients that overflow.
// ----------------------------------------------------------------------------
module pvp_divider #(
  parameter int AW = 37
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [AW+15:0]               in_num_x,
  input  logic [AW+15:0]               in_num_y,
  input  logic [AW-1:0]                in_den,
  input  pvp_pkg::side_t               in_side,
  output logic                         out_valid,
  output logic [pvp_pkg::DIV_STEPS-1:0] out_quo_x,
  output logic [pvp_pkg::DIV_STEPS-1:0] out_quo_y,
  output pvp_pkg::side_t               out_side
);

  localparam int NS = pvp_pkg::DIV_STEPS;
  localparam int DW = AW + NS - 1;

  logic                 vld_r  [NS];
  logic [DW-1:0]        remx_r [NS];
  logic [DW-1:0]        remy_r [NS];
  logic [AW-1:0]        den_r  [NS];
  logic [NS-1:0]        qx_r   [NS];
  logic [NS-1:0]        qy_r   [NS];
  pvp_pkg::side_t       side_r [NS];

  for (genvar s = 0; s < NS; s++) begin : g_step
    localparam int BIT = NS - 1 - s;
    logic                 v_in;
    logic [DW-1:0]        rx_in, ry_in;
    logic [AW-1:0]        d_in;
    logic [NS-1:0]        qx_in, qy_in;
    pvp_pkg::side_t       sd_in;
    logic [DW-1:0]        sub;
    logic                 ge_x, ge_y;

    if (s == 0) begin : g_first
      assign v_in  = in_valid;
      assign rx_in = DW'(in_num_x);
      assign ry_in = DW'(in_num_y);
      assign d_in  = in_den;
      assign qx_in = '0;
      assign qy_in = '0;
      assign sd_in = in_side;
    end else begin : g_next
      assign v_in  = vld_r[s-1];
      assign rx_in = remx_r[s-1];
      assign ry_in = remy_r[s-1];
      assign d_in  = den_r[s-1];
      assign qx_in = qx_r[s-1];
      assign qy_in = qy_r[s-1];
      assign sd_in = side_r[s-1];
    end

    // Trial subtract of the shifted divisor
    assign sub  = DW'(d_in) << BIT;
    assign ge_x = rx_in >= sub;
    assign ge_y = ry_in >= sub;

    // Advance one step
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s]  <= v_in;
        remx_r[s] <= ge_x ? rx_in - sub : rx_in;
        remy_r[s] <= ge_y ? ry_in - sub : ry_in;
        den_r[s]  <= d_in;
        qx_r[s]   <= qx_in | (NS'(ge_x) << BIT);
        qy_r[s]   <= qy_in | (NS'(ge_y) << BIT);
        side_r[s] <= sd_in;
      end
    end
  end

  assign out_valid = vld_r[NS-1];
  assign out_quo_x = qx_r[NS-1];
  assign out_quo_y = qy_r[NS-1];
  assign out_side  = side_r[NS-1];

endmodule

/* hdl/pvp_checker.sv */
// ----------------------------------------------------------------------------
// pvp_checker: port-level checks for the vertex projection block
// Watches the stream ports and the result flags over time.
// ----------------------------------------------------------------------------
module pvp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic [31:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tvalid,
  input logic        out_tready
);

  // Hold a stalled result transaction
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // Accept input whenever the output side can move
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready does not follow output stall");

  // Zero depth never reports clipping
  a_dz: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> !out_tuser[1])
    else $error("zero depth result marked clipped");

  // Clipped results sit on a limit
  a_clip: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |->
      out_tdata[15:0] == 16'h7FFF || out_tdata[15:0] == 16'h8000 ||
      out_tdata[31:16] == 16'h7FFF || out_tdata[31:16] == 16'h8000)
    else $error("clipped result not at a limit");

  // Drop valid after reset
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind perspective_vertex_projection pvp_checker u_pvp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);
